>>> hdl/bmp24_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types and constants of the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bmp24_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;

  localparam logic [7:0] CHAR_B = 8'h42;
  localparam logic [7:0] CHAR_M = 8'h4D;

  localparam logic [31:0] MIN_INFO_SIZE  = 32'd40;
  localparam logic [15:0] BITS_PER_PIXEL = 16'd24;
  localparam logic [31:0] HEADER_BYTES   = 32'd54;

  localparam logic [31:0] POS_SIG0      = 32'd0;
  localparam logic [31:0] POS_SIG1      = 32'd1;
  localparam logic [31:0] POS_OFFSET    = 32'd13;
  localparam logic [31:0] POS_INFO_SIZE = 32'd17;
  localparam logic [31:0] POS_WIDTH     = 32'd21;
  localparam logic [31:0] POS_HEIGHT    = 32'd25;
  localparam logic [31:0] POS_DEPTH     = 32'd29;
  localparam logic [31:0] POS_COMPRESS  = 32'd33;
  localparam logic [31:0] POS_LAST      = 32'd53;

  localparam logic       KIND_PIXEL = 1'b0;
  localparam logic       KIND_ERROR = 1'b1;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_SIGNATURE = 3'd1;
  localparam logic [2:0] ERR_FORMAT    = 3'd2;
  localparam logic [2:0] ERR_DIMENSION = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  localparam logic       REG_KEY_ENABLE = 1'b0;
  localparam logic       REG_KEY_COLOR  = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef struct packed {
    logic        result_kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [2:0]  error_code;
    logic        frame_done;
  } result_t;

endpackage

>>> hdl/bmp24_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Streaming decoder for uncompressed 24-bit BMP files, one byte per item.
// A result is registered in the output entry, or in the skid entry on a stall.
// Throughput: one byte per cycle unless in_stall; parse state updates in a single pass.
// A two-entry output register with skid entry keeps input and output apart.
// Synchronous active-low reset clears the parser, the output and the key.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [11:0] out_pixel_x,
  output logic [11:0] out_pixel_y,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height,
  output logic [2:0]  out_error_code,
  output logic        out_frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  logic               key_enable_r;
  logic [23:0]        key_color_r;
  logic               accept;
  logic               res_valid;
  bmp24_pkg::result_t res;
  logic               out_valid_r;
  bmp24_pkg::result_t out_r;
  logic               skid_valid_r;
  bmp24_pkg::result_t skid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_enable_r <= 1'b0;
      key_color_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bmp24_pkg::REG_KEY_ENABLE: key_enable_r <= cfg_data[0];
        bmp24_pkg::REG_KEY_COLOR:  key_color_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bmp24_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .key_enable  (key_enable_r),
    .key_color   (key_color_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      out_r        <= '0;
      skid_r       <= '0;
    end else if (skid_valid_r) begin
      if (!out_stall) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= accept && res_valid;
      if (accept && res_valid) begin
        out_r <= res;
      end
    end else if (accept && res_valid) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_r.result_kind;
  assign out_pixel_x      = out_r.pixel_x;
  assign out_pixel_y      = out_r.pixel_y;
  assign out_red          = out_r.red;
  assign out_green        = out_r.green;
  assign out_blue         = out_r.blue;
  assign out_alpha        = out_r.alpha;
  assign out_image_width  = out_r.image_width;
  assign out_image_height = out_r.image_height;
  assign out_error_code   = out_r.error_code;
  assign out_frame_done   = out_r.frame_done;

endmodule

>>> hdl/bmp24_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_parser
// Header parser and pixel assembler. Updates the parse state for each
// accepted byte and produces at most one result for it.
// ----------------------------------------------------------------------------
module bmp24_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                end_of_file,
  input  logic                key_enable,
  input  logic [23:0]         key_color,
  output logic                res_valid,
  output bmp24_pkg::result_t  res
);

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_SKIP   = 6'b000010,
    PH_PIXELS = 6'b000100,
    PH_TAIL   = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_ERROR  = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] fpos_r, fpos_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [12:0] width_r, width_nxt;
  logic        hneg_r, hneg_nxt;
  logic [12:0] habs_r, habs_nxt;
  logic        hok_r, hok_nxt;
  logic [2:0]  fmt_r, fmt_nxt;
  logic [11:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  green_r, green_nxt;

  logic [31:0] habs_full;
  logic [12:0] col_inc;
  logic [12:0] row_inc;
  logic [12:0] y_full;

  always_comb begin
    phase_nxt  = phase_r;
    fpos_nxt   = fpos_r;
    offset_nxt = offset_r;
    shift_nxt  = shift_r;
    width_nxt  = width_r;
    hneg_nxt   = hneg_r;
    habs_nxt   = habs_r;
    hok_nxt    = hok_r;
    fmt_nxt    = fmt_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    comp_nxt   = comp_r;
    pad_nxt    = pad_r;
    blue_nxt   = blue_r;
    green_nxt  = green_r;
    res_valid  = 1'b0;
    res        = '0;

    habs_full = shift_nxt;
    col_inc   = {1'b0, col_r} + 13'd1;
    row_inc   = {1'b0, row_r} + 13'd1;
    y_full    = habs_r - 13'd1 - {1'b0, row_r};

    unique case (phase_r)
      PH_HEADER: begin
        shift_nxt = {data_byte, shift_r[31:8]};
        fpos_nxt  = fpos_r + 32'd1;
        habs_full = shift_nxt[31] ? (32'd0 - shift_nxt) : shift_nxt;
        if ((fpos_r == bmp24_pkg::POS_SIG0 && data_byte != bmp24_pkg::CHAR_B) ||
            (fpos_r == bmp24_pkg::POS_SIG1 && data_byte != bmp24_pkg::CHAR_M)) begin
          res_valid        = 1'b1;
          res.result_kind  = bmp24_pkg::KIND_ERROR;
          res.error_code   = bmp24_pkg::ERR_SIGNATURE;
          phase_nxt        = PH_ERROR;
        end else begin
          if (fpos_r == bmp24_pkg::POS_OFFSET) begin
            offset_nxt = shift_nxt;
          end
          if (fpos_r == bmp24_pkg::POS_INFO_SIZE && shift_nxt >= bmp24_pkg::MIN_INFO_SIZE) begin
            fmt_nxt[0] = 1'b1;
          end
          if (fpos_r == bmp24_pkg::POS_WIDTH) begin
            width_nxt = (shift_nxt >= 32'd1 && shift_nxt <= 32'(bmp24_pkg::MAX_DIMENSION)) ?
                        shift_nxt[12:0] : 13'd0;
          end
          if (fpos_r == bmp24_pkg::POS_HEIGHT) begin
            hneg_nxt = shift_nxt[31];
            habs_nxt = habs_full[12:0];
            hok_nxt  = (habs_full != 32'd0) && (habs_full <= 32'(bmp24_pkg::MAX_DIMENSION));
          end
          if (fpos_r == bmp24_pkg::POS_DEPTH && shift_nxt[31:16] == bmp24_pkg::BITS_PER_PIXEL) begin
            fmt_nxt[1] = 1'b1;
          end
          if (fpos_r == bmp24_pkg::POS_COMPRESS && shift_nxt == 32'd0) begin
            fmt_nxt[2] = 1'b1;
          end
          if (fpos_r == bmp24_pkg::POS_LAST) begin
            if (fmt_r != 3'b111 || offset_r < bmp24_pkg::HEADER_BYTES) begin
              res_valid       = 1'b1;
              res.result_kind = bmp24_pkg::KIND_ERROR;
              res.error_code  = bmp24_pkg::ERR_FORMAT;
              phase_nxt       = PH_ERROR;
            end else if (width_r == 13'd0 || !hok_r) begin
              res_valid       = 1'b1;
              res.result_kind = bmp24_pkg::KIND_ERROR;
              res.error_code  = bmp24_pkg::ERR_DIMENSION;
              phase_nxt       = PH_ERROR;
            end else begin
              phase_nxt = (offset_r == bmp24_pkg::HEADER_BYTES) ? PH_PIXELS : PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        fpos_nxt = fpos_r + 32'd1;
        if (fpos_nxt == offset_r) begin
          phase_nxt = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (pad_r != 2'd0) begin
          pad_nxt = pad_r - 2'd1;
        end else begin
          unique case (comp_r)
            2'd0: begin
              blue_nxt = data_byte;
              comp_nxt = 2'd1;
            end
            2'd1: begin
              green_nxt = data_byte;
              comp_nxt  = 2'd2;
            end
            default: begin
              comp_nxt         = 2'd0;
              res_valid        = 1'b1;
              res.result_kind  = bmp24_pkg::KIND_PIXEL;
              res.pixel_x      = col_r;
              res.pixel_y      = hneg_r ? row_r : y_full[11:0];
              res.red          = data_byte;
              res.green        = green_r;
              res.blue         = blue_r;
              res.alpha        = (key_enable && {data_byte, green_r, blue_r} == key_color) ?
                                 bmp24_pkg::ALPHA_CLEAR : bmp24_pkg::ALPHA_OPAQUE;
              res.image_width  = width_r;
              res.image_height = habs_r;
              res.error_code   = bmp24_pkg::ERR_NONE;
              col_nxt          = col_inc[11:0];
              if (col_inc >= width_r) begin
                col_nxt = 12'd0;
                pad_nxt = width_r[1:0];
                row_nxt = row_inc[11:0];
                if (row_inc >= habs_r) begin
                  res.frame_done = 1'b1;
                  phase_nxt      = (width_r[1:0] != 2'd0) ? PH_TAIL : PH_DONE;
                end
              end
            end
          endcase
        end
      end
      PH_TAIL: begin
        pad_nxt = pad_r - 2'd1;
        if (pad_r == 2'd1) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_DONE, PH_ERROR: begin
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    if (end_of_file) begin
      if (phase_nxt != PH_DONE && phase_nxt != PH_ERROR) begin
        res_valid       = 1'b1;
        res             = '0;
        res.result_kind = bmp24_pkg::KIND_ERROR;
        res.error_code  = bmp24_pkg::ERR_TRUNCATED;
      end
      phase_nxt  = PH_HEADER;
      fpos_nxt   = '0;
      offset_nxt = '0;
      shift_nxt  = '0;
      width_nxt  = '0;
      hneg_nxt   = 1'b0;
      habs_nxt   = '0;
      hok_nxt    = 1'b0;
      fmt_nxt    = '0;
      col_nxt    = '0;
      row_nxt    = '0;
      comp_nxt   = '0;
      pad_nxt    = '0;
      blue_nxt   = '0;
      green_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      fpos_r   <= '0;
      offset_r <= '0;
      shift_r  <= '0;
      width_r  <= '0;
      hneg_r   <= 1'b0;
      habs_r   <= '0;
      hok_r    <= 1'b0;
      fmt_r    <= '0;
      col_r    <= '0;
      row_r    <= '0;
      comp_r   <= '0;
      pad_r    <= '0;
      blue_r   <= '0;
      green_r  <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      fpos_r   <= fpos_nxt;
      offset_r <= offset_nxt;
      shift_r  <= shift_nxt;
      width_r  <= width_nxt;
      hneg_r   <= hneg_nxt;
      habs_r   <= habs_nxt;
      hok_r    <= hok_nxt;
      fmt_r    <= fmt_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      comp_r   <= comp_nxt;
      pad_r    <= pad_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
    end
  end

endmodule
